### hw/rtl/rsosp_pkg.sv
// Shared constants, types and codes of the resampling one-shot sample player.
package rsosp_pkg;

  localparam int unsigned MaxEntries = 65536;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned LenW       = $clog2(MaxEntries + 1);
  localparam int unsigned SampleW    = 16;
  localparam int unsigned VelW       = 16;
  localparam int unsigned StepW      = 24;
  localparam int unsigned CountW     = 24;
  localparam int unsigned FracW      = 16;
  localparam int unsigned AccW       = IdxW + StepW;
  localparam int unsigned FuncW      = 2;

  localparam logic [StepW-1:0]  StepOne  = StepW'(65536);
  localparam logic [CountW-1:0] CountCap = '1;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned InDataW   = ((SampleW + VelW + 7) / 8) * 8;
  localparam int unsigned OutBits   = SampleW + 2 + LenW;
  localparam int unsigned OutDataW  = ((OutBits + 7) / 8) * 8;
  localparam int unsigned OutLoadedBit  = SampleW;
  localparam int unsigned OutPlayingBit = SampleW + 1;
  localparam int unsigned OutLenLsb     = SampleW + 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_TRIG  = 2'd1,
    FUNC_LOAD  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef struct packed {
    func_e                      func;
    logic signed [SampleW-1:0]  sample;
    logic                       last;
    logic [VelW-1:0]            velocity;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [CountW-1:0] count;
    logic [StepW-1:0]  step;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [LenW-1:0] quo;
  } div_rsp_t;

endpackage

### hw/rtl/rsosp_front.sv
// Front end: accepts input transactions, classifies them and queues the commands.
module rsosp_front import rsosp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,  // sample_value, velocity
  input  logic [FuncW-1:0]   s_axis_tuser,  // func
  input  logic               s_axis_tlast,  // last_sample
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_pop_i
);

  cmd_t             q_mem [QDepth];
  cmd_t             cmd_in;
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  always_comb begin
    cmd_in          = '0;
    cmd_in.last     = s_axis_tlast;
    case (s_axis_tuser)
      FUNC_TICK: begin
        cmd_in.func = FUNC_TICK;
      end
      FUNC_TRIG: begin
        cmd_in.func     = FUNC_TRIG;
        cmd_in.velocity = s_axis_tdata[SampleW +: VelW];
      end
      FUNC_LOAD: begin
        cmd_in.func   = FUNC_LOAD;
        cmd_in.sample = s_axis_tdata[SampleW-1:0];
      end
      FUNC_CLEAR: begin
        cmd_in.func = FUNC_CLEAR;
      end
      default: begin
        cmd_in.func = FUNC_TICK;
      end
    endcase
  end

  assign s_axis_tready = (cnt_q != QCntW'(QDepth));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != '0);
  assign pop           = cmd_pop_i && cmd_valid_o;
  assign cmd_o         = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/rsosp_div.sv
// Restoring divider that gives the resampled length and an overflow flag, one quotient bit per cycle.
module rsosp_div import rsosp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned DivW = CountW + FracW;
  localparam int unsigned CntW = $clog2(LenW + 1);

  logic [DivW-1:0]  dividend, hi;
  logic             ovf_start;
  logic [StepW:0]   trial;
  logic             ge;
  logic             busy_q, done_q, ovf_q;
  logic [CntW-1:0]  cnt_q;
  logic [StepW-1:0] rem_q;
  logic [LenW-1:0]  lo_q, quo_q;

  assign dividend  = {req_i.count, FracW'(0)};
  assign hi        = dividend >> LenW;
  assign ovf_start = (hi >= DivW'(req_i.step));
  assign trial     = {rem_q, lo_q[LenW-1]};
  assign ge        = (trial >= {1'b0, req_i.step});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= req_i.start ? ovf_start : (busy_q && (cnt_q == CntW'(1)));
      if (req_i.start) begin
        if (!ovf_start) begin
          busy_q <= 1'b1;
          cnt_q  <= CntW'(LenW);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ovf_q <= ovf_start;
      rem_q <= hi[StepW-1:0];
      lo_q  <= dividend[LenW-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? StepW'(trial - {1'b0, req_i.step}) : trial[StepW-1:0];
      lo_q  <= {lo_q[LenW-2:0], 1'b0};
      quo_q <= {quo_q[LenW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quo  = quo_q;

endmodule

### hw/rtl/rsosp_back.sv
// Back end: executes queued commands, holds the sample memory and the result register.
module rsosp_back import rsosp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [StepW-1:0]    step_ratio_i,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  output div_req_t            div_req_o,
  input  div_rsp_t            div_rsp_i,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata  // audio_out, is_loaded, is_playing, buffer_length
);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_TICK_MUL = 10'b00_0000_0010,
    ST_TICK_RND = 10'b00_0000_0100,
    ST_LOAD_CHK = 10'b00_0000_1000,
    ST_LOAD_MUL = 10'b00_0001_0000,
    ST_LOAD_WR  = 10'b00_0010_0000,
    ST_LAST     = 10'b00_0100_0000,
    ST_DIV      = 10'b00_1000_0000,
    ST_FILL_CHK = 10'b01_0000_0000,
    ST_RESP     = 10'b10_0000_0000
  } state_e;

  function automatic logic signed [SampleW-1:0] sat16(input logic signed [18:0] x);
    logic signed [SampleW-1:0] r;
    if (x > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (x < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[SampleW-1:0];
    end
    return r;
  endfunction

  state_e                    state_q, state_d;
  cmd_t                      cmd_q;
  logic                      loaded_q, loading_q, active_q, fill_q;
  logic [LenW-1:0]           len_q, widx_q, pos_q, len_new;
  logic [CountW-1:0]         src_cnt_q;
  logic [AccW-1:0]           acc_q;
  logic signed [SampleW-1:0] prev_q, s0_q, rd_q, audio_q;
  logic [VelW-1:0]           gain_q;
  logic signed [33:0]        prod_q, mul_p, ip_t, tk_t;
  logic signed [16:0]        mul_a, mul_b;
  logic signed [SampleW-1:0] s0_sel, s1_sel;
  logic signed [18:0]        ip_v, tk_r;
  logic [StepW-1:0]          eff_step;
  logic [AccW-1:0]           acc_pos;
  logic                      playing, out_free, pop, can_write, fill_match;
  logic                      m_valid_q;
  logic [OutDataW-1:0]       m_data_q;
  logic signed [SampleW-1:0] sample_mem [MaxEntries];

  assign eff_step   = (step_ratio_i == '0) ? StepOne : step_ratio_i;
  assign acc_pos    = AccW'(acc_q[AccW-1:FracW]);
  assign playing    = loaded_q && active_q && (pos_q < len_q);
  assign out_free   = !m_valid_q || m_axis_tready;
  assign pop        = (state_q == ST_IDLE) && cmd_valid_i;
  assign cmd_pop_o  = pop;
  assign can_write  = (widx_q < LenW'(MaxEntries)) && (acc_pos < AccW'(src_cnt_q));
  assign fill_match = (acc_pos == AccW'(src_cnt_q - CountW'(1)));

  assign s0_sel = (fill_q && !fill_match) ? '0 : prev_q;
  assign s1_sel = fill_q ? '0 : cmd_q.sample;

  always_comb begin
    if (state_q == ST_LOAD_MUL) begin
      mul_a = {1'b0, acc_q[FracW-1:0]};
      mul_b = {s1_sel[SampleW-1], s1_sel} - {s0_sel[SampleW-1], s0_sel};
    end else begin
      mul_a = {rd_q[SampleW-1], rd_q};
      mul_b = {1'b0, gain_q};
    end
  end

  assign mul_p = mul_a * mul_b;
  assign ip_t  = prod_q + 34'sd32768;
  assign ip_v  = 19'(s0_q) + 19'($signed(ip_t[33:16]));
  assign tk_t  = prod_q + 34'sd16384;
  assign tk_r  = $signed(tk_t[33:15]);

  always_comb begin
    if (div_rsp_i.ovf || (div_rsp_i.quo > LenW'(MaxEntries))) begin
      len_new = LenW'(MaxEntries);
    end else if (div_rsp_i.quo == '0) begin
      len_new = LenW'(1);
    end else begin
      len_new = div_rsp_i.quo;
    end
  end

  assign div_req_o.start = (state_q == ST_LAST) && cmd_q.last;
  assign div_req_o.count = src_cnt_q;
  assign div_req_o.step  = eff_step;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          case (cmd_i.func)
            FUNC_TICK: state_d = playing ? ST_TICK_MUL : ST_RESP;
            FUNC_LOAD: state_d = ST_LOAD_CHK;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_TICK_MUL: state_d = ST_TICK_RND;
      ST_TICK_RND: state_d = ST_RESP;
      ST_LOAD_CHK: begin
        state_d = ((src_cnt_q != CountCap) && can_write) ? ST_LOAD_MUL : ST_LAST;
      end
      ST_LOAD_MUL: state_d = ST_LOAD_WR;
      ST_LOAD_WR:  state_d = fill_q ? ST_FILL_CHK : ST_LOAD_CHK;
      ST_LAST:     state_d = cmd_q.last ? ST_DIV : ST_RESP;
      ST_DIV: begin
        if (div_rsp_i.done) begin
          state_d = ST_FILL_CHK;
        end
      end
      ST_FILL_CHK: state_d = (widx_q < len_q) ? ST_LOAD_MUL : ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      loaded_q  <= 1'b0;
      loading_q <= 1'b0;
      active_q  <= 1'b0;
      fill_q    <= 1'b0;
      len_q     <= '0;
      widx_q    <= '0;
      pos_q     <= '0;
      src_cnt_q <= '0;
      acc_q     <= '0;
      prev_q    <= '0;
      gain_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            case (cmd_i.func)
              FUNC_TRIG: begin
                if (loaded_q) begin
                  gain_q   <= cmd_i.velocity;
                  pos_q    <= '0;
                  active_q <= 1'b1;
                end
              end
              FUNC_LOAD: begin
                fill_q <= 1'b0;
                if (!loading_q) begin
                  loading_q <= 1'b1;
                  loaded_q  <= 1'b0;
                  active_q  <= 1'b0;
                  pos_q     <= '0;
                  len_q     <= '0;
                  src_cnt_q <= '0;
                  acc_q     <= '0;
                  widx_q    <= '0;
                  prev_q    <= '0;
                end
              end
              FUNC_CLEAR: begin
                loaded_q  <= 1'b0;
                loading_q <= 1'b0;
                active_q  <= 1'b0;
                pos_q     <= '0;
                len_q     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_TICK_RND: begin
          pos_q <= pos_q + 1'b1;
        end
        ST_LOAD_CHK: begin
          if ((src_cnt_q != CountCap) && !can_write) begin
            prev_q    <= cmd_q.sample;
            src_cnt_q <= src_cnt_q + 1'b1;
          end
        end
        ST_LOAD_WR: begin
          widx_q <= widx_q + 1'b1;
          acc_q  <= acc_q + AccW'(eff_step);
        end
        ST_DIV: begin
          if (div_rsp_i.done) begin
            len_q  <= len_new;
            fill_q <= 1'b1;
          end
        end
        ST_FILL_CHK: begin
          if (widx_q >= len_q) begin
            loading_q <= 1'b0;
            loaded_q  <= 1'b1;
            active_q  <= 1'b0;
            pos_q     <= '0;
          end
        end
        default: begin
        end
      endcase
      if ((state_q == ST_RESP) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q   <= cmd_i;
      audio_q <= '0;
    end
    if ((state_q == ST_TICK_MUL) || (state_q == ST_LOAD_MUL)) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_LOAD_MUL) begin
      s0_q <= s0_sel;
    end
    if (state_q == ST_TICK_RND) begin
      audio_q <= sat16(tk_r);
    end
    if ((state_q == ST_RESP) && out_free) begin
      m_data_q <= OutDataW'({len_q, playing, loaded_q, audio_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD_WR) begin
      sample_mem[widx_q[IdxW-1:0]] <= sat16(ip_v);
    end
    rd_q <= sample_mem[pos_q[IdxW-1:0]];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### hw/rtl/resampling_one_shot_sample_player_unit.sv
// Top level of the resampling one-shot sample player.
// Each input transaction gives exactly one result transaction, in order. A tick that renders
// a sample passes through a multiply and a rounding state before the response state, and a
// silent tick, a trigger or a clear goes straight to it; each then waits there for the
// result register to be free. A load transaction checks, multiplies and writes each
// resampled entry in turn, as every entry passes through the one shared multiplier and the
// single write port of the sample memory; the marked last sample adds a bit-serial length
// division and the final fill of the remaining entries. A two-entry command queue lets new
// transactions be accepted while the back end works, and the result register lets the
// back end finish while the output is stalled. The sample memory has no reset and needs
// no clearing pass: playback only ever reads entries written by the last complete load.
module resampling_one_shot_sample_player_unit import rsosp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [StepW-1:0]    cfg_wdata_i,    // step_ratio
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // sample_value, velocity
  input  logic [FuncW-1:0]    s_axis_tuser,   // func
  input  logic                s_axis_tlast,   // last_sample
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // audio_out, is_loaded, is_playing, buffer_length
);

  logic [StepW-1:0] step_ratio_q;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ratio_q <= StepOne;
    end else if (cfg_we_i) begin
      step_ratio_q <= cfg_wdata_i;
    end
  end

  rsosp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  rsosp_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  rsosp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_ratio_i (step_ratio_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  ap_playing_needs_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[OutPlayingBit] || m_axis_tdata[OutLoadedBit]))
    else $error("Playing reported while the buffer is not loaded.");

  ap_loaded_means_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[OutLoadedBit] == (m_axis_tdata[OutLenLsb +: LenW] != '0)))
    else $error("Loaded flag and stored length disagree.");

  ap_length_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutLenLsb +: LenW] <= LenW'(MaxEntries)))
    else $error("Stored length exceeds the sample memory depth.");
`endif

endmodule
